// ===== rtl/utf8s_pkg.sv =====
// Shared types and constants for the UTF-8 sanitizer.
package utf8s_pkg;

    // Byte classes
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;

    // U+FFFD encoding
    localparam logic [7:0] REPL_BYTE0  = 8'hEF;
    localparam logic [7:0] REPL_BYTE1  = 8'hBF;
    localparam logic [7:0] REPL_BYTE2  = 8'hBD;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE    = 3'd0;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    // Position of the current byte within one replacement
    localparam logic [1:0] SUB_FIRST   = 2'd0;
    localparam logic [1:0] SUB_MID     = 2'd1;
    localparam logic [1:0] SUB_LAST    = 2'd2;

    localparam int QUEUE_DEPTH_DEF     = 2;

    // One output run: repl_cnt replacements, then pass_cnt literal bytes
    typedef struct packed {
        logic [2:0]      repl_cnt;
        logic [2:0]      pass_cnt;
        logic [3:0][7:0] pass_bytes;
        logic            eot;
    } cmd_t;

endpackage

// ===== rtl/utf8_sanitizer.sv =====
// UTF-8 sanitizer top level: front end, command queue, back end.
//
// Input stream: s_tdata[7:0] carries one raw byte per transaction, s_tlast
// marks the final byte of a text. Output stream: m_tdata[7:0] is a sanitized
// byte, m_tlast marks the final output byte caused by one input byte, and
// m_tuser marks the final output byte of the whole text.
// Valid multibyte sequences are held until complete, then released intact;
// bad bytes and broken sequences come out as EF BF BD.
// Throughput: one input byte per cycle while the queue has room, one output
// byte per cycle while m_tready is high; one input byte can yield up to 12
// output bytes, and the front end runs ahead until the command queue
// (QUEUE_DEPTH entries) is full. The output bytes of a run follow the
// transaction that completes it, once its command has passed through the
// queue and the back end's run register.
// Reset (aresetn low, synchronous) empties the queue and closes any open
// sequence. When the receiver holds m_tready low the current byte holds and
// the queue fills; then s_tready drops until the back end moves on.
module utf8_sanitizer #(
    parameter int QUEUE_DEPTH = utf8s_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] text_last
);
    import utf8s_pkg::*;

    cmd_t push_cmd, head_cmd;
    logic push, full, pop, not_empty;

    utf8s_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_eot   (s_tlast),
        .in_ready (s_tready),
        .q_full   (full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    utf8s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    utf8s_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (not_empty),
        .q_cmd         (head_cmd),
        .q_pop         (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_run_last  (m_tlast),
        .out_text_last (m_tuser)
    );

endmodule

// ===== rtl/utf8s_front.sv =====
// Front end: accepts input bytes, tracks the open sequence, builds run commands.
module utf8s_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_eot,
    output logic               in_ready,
    input  logic               q_full,
    output logic               q_push,
    output utf8s_pkg::cmd_t    q_cmd
);
    import utf8s_pkg::*;

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0]      need_reg, need_next;

    logic            accept;
    logic            is_cont;
    logic [2:0]      cnt_ext;
    cmd_t            cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_cont  = (in_byte & CONT_MASK) == CONT_TAG;
    assign cnt_ext  = {1'b0, cnt_reg};

    // Classify the byte against the open sequence
    always_comb begin
        logic fresh;
        held_next    = held_reg;
        cnt_next     = cnt_reg;
        need_next    = need_reg;
        cmd.repl_cnt = 3'd0;
        cmd.pass_cnt = 3'd0;
        cmd.eot      = in_eot;
        fresh        = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (3'(i) < cnt_ext) begin
                cmd.pass_bytes[i] = held_reg[i];
            end else begin
                cmd.pass_bytes[i] = in_byte;
            end
        end
        cmd.pass_bytes[3] = in_byte;

        if (need_reg != LEN_NONE) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (cnt_ext + 3'd1 >= need_reg) begin
                    // sequence complete: pass all held bytes plus this one
                    cmd.pass_cnt = cnt_ext + 3'd1;
                    cnt_next     = 2'd0;
                    need_next    = LEN_NONE;
                end else begin
                    held_next[cnt_reg] = in_byte;
                    cnt_next           = cnt_reg + 2'd1;
                    if (in_eot) begin
                        cmd.repl_cnt = cnt_ext + 3'd1;
                        cnt_next     = 2'd0;
                        need_next    = LEN_NONE;
                    end
                end
            end else begin
                // broken sequence: every held byte becomes a replacement
                cmd.repl_cnt = cnt_ext;
                cnt_next     = 2'd0;
                need_next    = LEN_NONE;
            end
        end

        if (fresh) begin
            if (in_byte <= ASCII_MAX) begin
                cmd.pass_bytes[0] = in_byte;
                cmd.pass_cnt      = 3'd1;
            end else if (in_byte >= LEAD2_MIN && in_byte <= LEAD4_MAX) begin
                held_next[0] = in_byte;
                cnt_next     = 2'd1;
                if (in_byte <= LEAD2_MAX) begin
                    need_next = LEN_TWO;
                end else if (in_byte >= LEAD3_MIN && in_byte <= LEAD3_MAX) begin
                    need_next = LEN_THREE;
                end else begin
                    need_next = LEN_FOUR;
                end
                // end of text flushes the lone lead
                if (in_eot) begin
                    cmd.repl_cnt = cmd.repl_cnt + 3'd1;
                    cnt_next     = 2'd0;
                    need_next    = LEN_NONE;
                end
            end else begin
                cmd.repl_cnt = cmd.repl_cnt + 3'd1;
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.repl_cnt != 3'd0 || cmd.pass_cnt != 3'd0);

    // Sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            need_reg <= LEN_NONE;
        end else if (accept) begin
            cnt_reg  <= cnt_next;
            need_reg <= need_next;
        end
    end

    // Held bytes carry no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/utf8s_queue.sv =====
// Short command queue between the front and back ends.
module utf8s_queue #(
    parameter int DEPTH = utf8s_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  utf8s_pkg::cmd_t    push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output utf8s_pkg::cmd_t    head_cmd
);
    import utf8s_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full      = count_reg == CNT_FULL;
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = mem[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/utf8s_back.sv =====
// Back end: plays out one run command as a byte stream.
module utf8s_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  utf8s_pkg::cmd_t    q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_run_last,
    output logic               out_text_last
);
    import utf8s_pkg::*;

    cmd_t        cur_reg;
    logic        valid_reg;
    logic [2:0]  repl_left_reg;
    logic [1:0]  sub_reg;
    logic [1:0]  pass_idx_reg;

    logic        last;
    logic        advance;
    logic        load;

    // Current byte and end-of-run flag
    always_comb begin
        if (repl_left_reg != 3'd0) begin
            unique case (sub_reg)
                SUB_FIRST: out_byte = REPL_BYTE0;
                SUB_MID:   out_byte = REPL_BYTE1;
                default:   out_byte = REPL_BYTE2;
            endcase
            last = repl_left_reg == 3'd1 && sub_reg == SUB_LAST
                   && cur_reg.pass_cnt == 3'd0;
        end else begin
            out_byte = cur_reg.pass_bytes[pass_idx_reg];
            last     = {1'b0, pass_idx_reg} + 3'd1 == cur_reg.pass_cnt;
        end
    end

    assign out_valid     = valid_reg;
    assign out_run_last  = last;
    assign out_text_last = last && cur_reg.eot;
    assign advance       = valid_reg && out_ready;
    assign load          = !valid_reg || (advance && last);
    assign q_pop         = load && q_not_empty;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg       <= q_cmd;
            repl_left_reg <= q_cmd.repl_cnt;
            sub_reg       <= SUB_FIRST;
            pass_idx_reg  <= 2'd0;
        end else if (advance) begin
            if (repl_left_reg != 3'd0) begin
                if (sub_reg == SUB_LAST) begin
                    sub_reg       <= SUB_FIRST;
                    repl_left_reg <= repl_left_reg - 3'd1;
                end else begin
                    sub_reg <= sub_reg + 2'd1;
                end
            end else begin
                pass_idx_reg <= pass_idx_reg + 2'd1;
            end
        end
    end

endmodule

// ===== tb/sv/utf8_sanitizer_checker.sv =====
// Checker for the UTF-8 sanitizer: watches both streams, predicts and compares output bytes.
module utf8_sanitizer_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // run_last
    input  logic       m_tuser,   // [0] text_last
    output int         err_cnt,
    output int         pending_cnt
);
    import utf8s_pkg::*;

    localparam int EXP_DEPTH = 4096;
    localparam int RUN_MAX   = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_last;
    } out_byte_t;

    // Expected output bytes, oldest at exp_rd
    out_byte_t  exp_mem[EXP_DEPTH];
    int         exp_wr;
    int         exp_rd;
    // Bytes produced by the transaction being predicted
    logic [7:0] run_buf[RUN_MAX];
    int         run_n;

    // Predictor copy of the sequence state
    logic [7:0] held_seq[3];
    logic [1:0] held_cnt;
    logic [2:0] seq_len;
    int         errs;

    initial begin
        err_cnt     = 0;
        pending_cnt = 0;
        errs        = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        run_n       = 0;
    end

    task automatic add_run_byte(input logic [7:0] b);
        run_buf[run_n] = b;
        run_n++;
    endtask

    task automatic add_repl();
        add_run_byte(REPL_BYTE0);
        add_run_byte(REPL_BYTE1);
        add_run_byte(REPL_BYTE2);
    endtask

    // Broken sequence: one U+FFFD per held byte, then close it
    task automatic flush_held();
        for (int i = 0; i < int'(held_cnt); i++) begin
            add_repl();
        end
        held_cnt = 2'd0;
        seq_len  = LEN_NONE;
    endtask

    // Work out the output bytes caused by one input byte
    task automatic predict_sanitized(input logic [7:0] b, input logic eot);
        logic      taken;
        out_byte_t rec;
        taken = 1'b0;
        run_n = 0;

        if (seq_len != LEN_NONE) begin
            if ((b & CONT_MASK) == CONT_TAG) begin
                taken = 1'b1;
                if (int'(held_cnt) + 1 >= int'(seq_len)) begin
                    for (int i = 0; i < int'(held_cnt); i++) begin
                        add_run_byte(held_seq[i]);
                    end
                    add_run_byte(b);
                    held_cnt = 2'd0;
                    seq_len  = LEN_NONE;
                end else begin
                    held_seq[held_cnt] = b;
                    held_cnt           = held_cnt + 2'd1;
                end
            end else begin
                flush_held();
            end
        end

        // Fresh input: pass ASCII, open a sequence on a lead, else replace
        if (!taken) begin
            if (b <= ASCII_MAX) begin
                add_run_byte(b);
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                held_seq[0] = b;
                held_cnt    = 2'd1;
                seq_len     = LEN_TWO;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                held_seq[0] = b;
                held_cnt    = 2'd1;
                seq_len     = LEN_THREE;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                held_seq[0] = b;
                held_cnt    = 2'd1;
                seq_len     = LEN_FOUR;
            end else begin
                add_repl();
            end
        end

        // End of text closes any open sequence
        if (eot && seq_len != LEN_NONE) begin
            flush_held();
        end

        for (int i = 0; i < run_n; i++) begin
            rec.data      = run_buf[i];
            rec.run_last  = (i == run_n - 1);
            rec.text_last = (i == run_n - 1) && eot;
            exp_mem[exp_wr % EXP_DEPTH] = rec;
            exp_wr++;
        end
    endtask

    // Predict on input transactions, compare on output transactions
    always @(posedge aclk) begin
        out_byte_t exp_rec;
        if (!aresetn) begin
            exp_wr      = 0;
            exp_rd      = 0;
            held_seq[0] = 8'h00;
            held_seq[1] = 8'h00;
            held_seq[2] = 8'h00;
            held_cnt    = 2'd0;
            seq_len     = LEN_NONE;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_sanitized(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (exp_wr == exp_rd) begin
                    errs++;
                    $display("%0t: unexpected output: expected none, actual %h/%b/%b",
                             $time, m_tdata, m_tlast, m_tuser);
                end else begin
                    exp_rec = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (exp_rec.data !== m_tdata || exp_rec.run_last !== m_tlast ||
                        exp_rec.text_last !== m_tuser) begin
                        errs++;
                        $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
                                 $time, exp_rec.data, exp_rec.run_last,
                                 exp_rec.text_last, m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
        err_cnt     <= errs;
        pending_cnt <= exp_wr - exp_rd;
    end

endmodule

// ===== tb/sv/tb_utf8_sanitizer.sv =====
// Testbench top for the UTF-8 sanitizer: clock, reset, stimulus and verdict.
module tb_utf8_sanitizer;
    import utf8s_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_LEN   = 300;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    int   err_cnt;
    int   pending_cnt;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   bytes_sent  = 0;
    int   cycle_cnt   = 0;
    int   stall_left  = 0;
    logic stall_req   = 1'b0;
    logic stall_taken = 1'b0;

    utf8_sanitizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    utf8_sanitizer_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .err_cnt     (err_cnt),
        .pending_cnt (pending_cnt)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random ready, or one long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_req && !stall_taken) begin
            m_tready    <= 1'b0;
            stall_left  <= STALL_LEN;
            stall_taken <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Stop offering bytes until every predicted output byte has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0) @(posedge aclk);
    endtask

    // One random character: mostly well formed, some truncated, corrupt or stray
    task automatic send_symbol();
        logic [7:0] seq[4];
        int         len;
        int         kind;
        int         pos;
        logic       eot;
        kind = $urandom_range(99);
        eot  = ($urandom_range(15) == 0);
        len  = 1;
        for (int i = 1; i < 4; i++) begin
            seq[i] = 8'h80 | 8'($urandom_range(63));
        end
        if (kind < 25) begin
            seq[0] = 8'($urandom_range(ASCII_MAX));
        end else if (kind < 40) begin
            seq[0] = 8'($urandom_range(LEAD2_MAX, LEAD2_MIN));
            len    = 2;
        end else if (kind < 55) begin
            seq[0] = 8'($urandom_range(LEAD3_MAX, LEAD3_MIN));
            len    = 3;
        end else if (kind < 72) begin
            seq[0] = 8'($urandom_range(LEAD4_MAX, LEAD4_MIN));
            len    = 4;
        end else if (kind < 82) begin
            // any byte at all, stray continuations and bad leads among them
            seq[0] = 8'($urandom_range(255));
        end else begin
            seq[0] = 8'($urandom_range(LEAD4_MAX, LEAD2_MIN));
            len    = (seq[0] >= LEAD4_MIN) ? 4 : (seq[0] >= LEAD3_MIN) ? 3 : 2;
            if (kind < 91) begin
                // truncated sequence
                len = $urandom_range(len - 1, 1);
            end else begin
                // corrupt byte somewhere after the lead
                pos      = $urandom_range(len - 1, 1);
                seq[pos] = 8'($urandom_range(255));
            end
        end
        for (int i = 0; i < len; i++) begin
            send_byte(seq[i], eot && (i == len - 1));
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int target);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        while (bytes_sent < target) send_symbol();
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: ASCII extremes, stray continuations, C0/C1
        tx_idle_pct <= 15;
        rx_idle_pct <= 54;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hC1, 1'b0);
        // well-formed two, three and four byte sequences at the lead limits
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // bad start bytes above F4
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b0);
        // non-continuation while open, ending the text
        send_byte(8'hEF, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b1);
        // end of text while open: flush of three held bytes
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b1);
        // lone lead ending a text, then a byte starting the next text
        send_byte(8'hC3, 1'b1);
        send_byte(8'h5A, 1'b0);
        wait_drained();

        run_phase(15, 54, bytes_sent + 70);
        run_phase(54, 15, bytes_sent + 70);

        // No idling; the receiver holds off for a long stretch at the start
        stall_req <= 1'b1;
        run_phase(0, 0, bytes_sent + 70);

        repeat (20) @(posedge aclk);
        if (err_cnt == 0 && pending_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/utf8s_pkg.sv
rtl/utf8s_front.sv
rtl/utf8s_queue.sv
rtl/utf8s_back.sv
rtl/utf8_sanitizer.sv
tb/sv/utf8_sanitizer_checker.sv
tb/sv/tb_utf8_sanitizer.sv
